FILE: hw/rtl/hsev_pkg.sv
// Shared types and codes for the cubic Hermite segment evaluator.
// No dependencies; the core refers to everything here by scoped name.
package hsev_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_POINT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TANGENT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_POINT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_TANGENT   = 3'd3;

  // Evaluation modes.
  localparam logic MODE_POSITION = 1'b0;
  localparam logic MODE_TANGENT  = 1'b1;

  // Number of spatial components.
  localparam int unsigned NUM_LANES = 3;

  // Control that travels down the pipeline with each beat.
  typedef struct packed {
    logic mode;
    logic at_start;
    logic at_end;
  } stage_ctl_t;

endpackage

FILE: hw/rtl/hermite_segment_evaluator_core.sv
// Cubic Hermite segment evaluator core: six-stage fixed-point pipeline.
// Depends on hsev_pkg for register codes, modes and the stage control struct.
//
// Channel   | Handshake            | Payload
// ----------+----------------------+----------------------------------------
// input     | start_i / busy_o     | param_t_i, mode_i
// result    | done_o (one cycle)   | x_out_o, y_out_o, z_out_o, saturated_o
// config    | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
// One beat is accepted every cycle; busy_o stays low. A beat passes through the
// capture of t, t^2, t^3 with the square and linear products, the cubic product
// and partial sum, the constant-term sum and round/saturate, each behind its own
// register. Reset clears the valid bits, the segment registers and the coefficients.
// The receiver cannot stall, so the pipeline advances on every clock.
module hermite_segment_evaluator_core #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned T_FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [hsev_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [3*COORD_WIDTH-1:0]             cfg_wdata_i,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [T_FRAC_BITS:0]                 param_t_i,
  input  logic                                 mode_i,
  output logic                                 done_o,
  output logic signed [COORD_WIDTH-1:0]        x_out_o,
  output logic signed [COORD_WIDTH-1:0]        y_out_o,
  output logic signed [COORD_WIDTH-1:0]        z_out_o,
  output logic                                 saturated_o
);

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned F    = T_FRAC_BITS;
  localparam int unsigned RW   = 3 * CW;
  localparam int unsigned CFW  = CW + 4;      // coefficient width
  localparam int unsigned MW   = CW + 6;      // multiplier operand width
  localparam int unsigned SW   = CW + F + 7;  // accumulation width
  localparam int unsigned NL   = hsev_pkg::NUM_LANES;
  localparam int unsigned LAT  = 6;

  localparam logic [2*F-1:0] HALF_SQ = {{F{1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [SW-1:0] HALF_SUM = {{(SW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [SW-1:0] OUT_MAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] OUT_MIN = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  // Segment registers.
  logic [RW-1:0] start_point_q, start_tangent_q, end_point_q, end_tangent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_point_q   <= '0;
      start_tangent_q <= '0;
      end_point_q     <= '0;
      end_tangent_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hsev_pkg::CFG_START_POINT:   start_point_q   <= cfg_wdata_i;
        hsev_pkg::CFG_START_TANGENT: start_tangent_q <= cfg_wdata_i;
        hsev_pkg::CFG_END_POINT:     end_point_q     <= cfg_wdata_i;
        hsev_pkg::CFG_END_TANGENT:   end_tangent_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Cubic and square coefficients follow the segment registers in the next cycle.
  logic signed [CFW-1:0] coeff_cubic_q [NL];
  logic signed [CFW-1:0] coeff_square_q [NL];
  logic signed [CFW-1:0] coeff_cubic_d [NL];
  logic signed [CFW-1:0] coeff_square_d [NL];
  logic signed [CFW-1:0] y0_c [NL];
  logic signed [CFW-1:0] y1_c [NL];
  logic signed [CFW-1:0] s0_c [NL];
  logic signed [CFW-1:0] s1_c [NL];
  logic signed [CFW-1:0] dy_c [NL];

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      y0_c[k] = CFW'($signed(start_point_q[k*CW +: CW]));
      s0_c[k] = CFW'($signed(start_tangent_q[k*CW +: CW]));
      y1_c[k] = CFW'($signed(end_point_q[k*CW +: CW]));
      s1_c[k] = CFW'($signed(end_tangent_q[k*CW +: CW]));
      dy_c[k] = y1_c[k] - y0_c[k];
      coeff_cubic_d[k]  = s0_c[k] + s1_c[k] - (dy_c[k] <<< 1);
      coeff_square_d[k] = dy_c[k] + (dy_c[k] <<< 1) - (s0_c[k] <<< 1) - s1_c[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NL; k++) begin
        coeff_cubic_q[k]  <= '0;
        coeff_square_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < NL; k++) begin
        coeff_cubic_q[k]  <= coeff_cubic_d[k];
        coeff_square_q[k] <= coeff_square_d[k];
      end
    end
  end

  // Valid bits and per-beat control, one entry per pipeline register.
  logic                 accept;
  logic [LAT-2:0]       vld_q;
  hsev_pkg::stage_ctl_t ctl_q [LAT-1];
  logic                 done_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[LAT-3:0], accept};
      done_q <= vld_q[LAT-2];
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q[0].mode     <= mode_i;
    ctl_q[0].at_start <= (param_t_i == '0);
    ctl_q[0].at_end   <= param_t_i[F];
    for (int s = 1; s < LAT - 1; s++) begin
      ctl_q[s] <= ctl_q[s-1];
    end
  end

  // Stage 1: capture t. Stage 2: t^2 rounded back to the fraction width.
  logic [F-1:0]   t1_q, t2s_q, sq_q, cube_q;
  logic [2*F-1:0] sq_full, cube_full;

  assign sq_full   = (2*F)'(t1_q) * (2*F)'(t1_q) + HALF_SQ;
  assign cube_full = (2*F)'(sq_q) * (2*F)'(t2s_q) + HALF_SQ;

  always_ff @(posedge clk_i) begin
    t1_q   <= param_t_i[F-1:0];
    t2s_q  <= t1_q;
    sq_q   <= sq_full[2*F-1:F];
    cube_q <= cube_full[2*F-1:F];
  end

  // Stage 3: square-term and linear-term products per lane, plus t^3.
  // Position uses b*t2 + c*t; tangent uses 3a*t2 + 2b*t.
  logic signed [MW-1:0] op_sq [NL];
  logic signed [MW-1:0] op_lin [NL];
  logic signed [MW-1:0] a_ext [NL];
  logic signed [MW-1:0] b_ext [NL];
  logic signed [SW-1:0] pm_sq_q [NL];
  logic signed [SW-1:0] pm_lin_q [NL];

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      a_ext[k] = MW'(coeff_cubic_q[k]);
      b_ext[k] = MW'(coeff_square_q[k]);
      if (ctl_q[1].mode == hsev_pkg::MODE_TANGENT) begin
        op_sq[k]  = a_ext[k] + (a_ext[k] <<< 1);
        op_lin[k] = b_ext[k] <<< 1;
      end else begin
        op_sq[k]  = b_ext[k];
        op_lin[k] = MW'($signed(start_tangent_q[k*CW +: CW]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NL; k++) begin
      pm_sq_q[k]  <= SW'(op_sq[k]) * SW'($signed({1'b0, sq_q}));
      pm_lin_q[k] <= SW'(op_lin[k]) * SW'($signed({1'b0, t2s_q}));
    end
  end

  // Stage 4: cubic product (position only) and the partial sum.
  logic signed [CFW-1:0] op_cub [NL];
  logic signed [SW-1:0]  pm_cub_q [NL];
  logic signed [SW-1:0]  part_q [NL];

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      op_cub[k] = (ctl_q[2].mode == hsev_pkg::MODE_TANGENT) ? '0 : coeff_cubic_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NL; k++) begin
      pm_cub_q[k] <= SW'(op_cub[k]) * SW'($signed({1'b0, cube_q}));
      part_q[k]   <= pm_sq_q[k] + pm_lin_q[k];
    end
  end

  // Stage 5: add the constant term, d for position and c for tangent.
  logic signed [SW-1:0] const_term [NL];
  logic signed [SW-1:0] sum_q [NL];

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      if (ctl_q[3].mode == hsev_pkg::MODE_TANGENT) begin
        const_term[k] = SW'($signed(start_tangent_q[k*CW +: CW])) <<< F;
      end else begin
        const_term[k] = SW'($signed(start_point_q[k*CW +: CW])) <<< F;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NL; k++) begin
      sum_q[k] <= pm_cub_q[k] + part_q[k] + const_term[k];
    end
  end

  // Stage 6: round half up, saturate, or pass the clamped endpoint value.
  logic signed [SW-1:0] rnd_v [NL];
  logic signed [CW-1:0] lane_d [NL];
  logic [NL-1:0]        lane_sat;
  logic [RW-1:0]        clamp_reg;
  logic signed [CW-1:0] lane_q [NL];
  logic                 sat_q;

  always_comb begin
    if (ctl_q[4].at_start) begin
      clamp_reg = (ctl_q[4].mode == hsev_pkg::MODE_TANGENT) ? start_tangent_q : start_point_q;
    end else begin
      clamp_reg = (ctl_q[4].mode == hsev_pkg::MODE_TANGENT) ? end_tangent_q : end_point_q;
    end
    for (int k = 0; k < NL; k++) begin
      rnd_v[k] = (sum_q[k] + HALF_SUM) >>> F;
      if (ctl_q[4].at_start || ctl_q[4].at_end) begin
        lane_d[k]   = clamp_reg[k*CW +: CW];
        lane_sat[k] = 1'b0;
      end else if (rnd_v[k] > OUT_MAX) begin
        lane_d[k]   = OUT_MAX[CW-1:0];
        lane_sat[k] = 1'b1;
      end else if (rnd_v[k] < OUT_MIN) begin
        lane_d[k]   = OUT_MIN[CW-1:0];
        lane_sat[k] = 1'b1;
      end else begin
        lane_d[k]   = rnd_v[k][CW-1:0];
        lane_sat[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NL; k++) begin
      lane_q[k] <= lane_d[k];
    end
    sat_q <= |lane_sat;
  end

  assign done_o      = done_q;
  assign x_out_o     = lane_q[0];
  assign y_out_o     = lane_q[1];
  assign z_out_o     = lane_q[2];
  assign saturated_o = sat_q;

  // Every accepted beat yields a result strobe once it has passed through the pipeline.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT done_o)
    else $error("result strobe missing after accepted beat");

  // A saturated result has at least one component pinned at a bound.
  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && saturated_o) |->
      (x_out_o == OUT_MAX[CW-1:0] || x_out_o == OUT_MIN[CW-1:0] ||
       y_out_o == OUT_MAX[CW-1:0] || y_out_o == OUT_MIN[CW-1:0] ||
       z_out_o == OUT_MAX[CW-1:0] || z_out_o == OUT_MIN[CW-1:0]))
    else $error("saturation flag set with no component at a bound");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for hermite_segment_evaluator_core: random and directed samples
// of a cubic Hermite segment, checked against a fixed-point model of the curve.
// Depends on hsev_pkg and the core RTL; nothing else is read.

// Mirrors the segment registers and holds the curve points expected from accepted beats.
class curve_checker;
  localparam int CW = 16;
  localparam int TF = 16;
  localparam longint OUT_MAX = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint OUT_MIN = -(longint'(1) <<< (CW - 1));

  typedef struct packed {
    logic              sat;
    logic [2:0][CW-1:0] lane;
  } curve_point_t;

  logic [3*CW-1:0] start_point;
  logic [3*CW-1:0] start_tangent;
  logic [3*CW-1:0] end_point;
  logic [3*CW-1:0] end_tangent;
  longint          cubic_k[3];
  longint          square_k[3];
  curve_point_t    pending_points[$];
  int              fail_count;

  function new();
    start_point   = '0;
    start_tangent = '0;
    end_point     = '0;
    end_tangent   = '0;
    fail_count    = 0;
    refresh_coeffs();
  endfunction

  // Sign-extends one Q8.8 component of a packed register.
  function longint lane_value(logic [3*CW-1:0] r, int k);
    logic signed [CW-1:0] v;
    v = r[k*CW +: CW];
    return longint'(v);
  endfunction

  // Round half up and drop the fraction bits of t.
  function longint round_q(longint v);
    return (v + (longint'(1) <<< (TF - 1))) >>> TF;
  endfunction

  function void refresh_coeffs();
    longint dy;
    longint s0;
    longint s1;
    for (int k = 0; k < 3; k++) begin
      dy          = lane_value(end_point, k) - lane_value(start_point, k);
      s0          = lane_value(start_tangent, k);
      s1          = lane_value(end_tangent, k);
      cubic_k[k]  = -2 * dy + s0 + s1;
      square_k[k] = 3 * dy - 2 * s0 - s1;
    end
  endfunction

  // Register write; indexes outside the four segment registers are ignored.
  function void write_reg(logic [hsev_pkg::CFG_IDX_W-1:0] idx, logic [3*CW-1:0] data);
    case (idx)
      hsev_pkg::CFG_START_POINT:   start_point   = data;
      hsev_pkg::CFG_START_TANGENT: start_tangent = data;
      hsev_pkg::CFG_END_POINT:     end_point     = data;
      hsev_pkg::CFG_END_TANGENT:   end_tangent   = data;
      default: return;
    endcase
    refresh_coeffs();
  endfunction

  // Position or tangent of the segment at t, with the end clamps and saturation.
  function curve_point_t predict_sample(logic [TF:0] t, logic mode);
    curve_point_t    p;
    logic [3*CW-1:0] clamp_reg;
    longint          tv;
    longint          t2;
    longint          t3;
    longint          sum;
    longint          r;
    p  = '0;
    tv = longint'(t);
    if (tv == 0 || tv >= (longint'(1) <<< TF)) begin
      if (tv == 0) begin
        clamp_reg = (mode == hsev_pkg::MODE_TANGENT) ? start_tangent : start_point;
      end else begin
        clamp_reg = (mode == hsev_pkg::MODE_TANGENT) ? end_tangent : end_point;
      end
      for (int k = 0; k < 3; k++) p.lane[k] = clamp_reg[k*CW +: CW];
      return p;
    end
    t2 = round_q(tv * tv);
    t3 = round_q(t2 * tv);
    for (int k = 0; k < 3; k++) begin
      if (mode == hsev_pkg::MODE_POSITION) begin
        sum = cubic_k[k] * t3 + square_k[k] * t2 + lane_value(start_tangent, k) * tv
            + (lane_value(start_point, k) <<< TF);
      end else begin
        sum = 3 * cubic_k[k] * t2 + 2 * square_k[k] * tv
            + (lane_value(start_tangent, k) <<< TF);
      end
      r = round_q(sum);
      if (r > OUT_MAX) begin
        r     = OUT_MAX;
        p.sat = 1'b1;
      end
      if (r < OUT_MIN) begin
        r     = OUT_MIN;
        p.sat = 1'b1;
      end
      p.lane[k] = r[CW-1:0];
    end
    return p;
  endfunction

  function void note_sample(logic [TF:0] t, logic mode);
    pending_points.insert(pending_points.size(), predict_sample(t, mode));
  endfunction

  // Compares one result beat with the oldest expected point.
  function void check_output(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
                             logic sat);
    curve_point_t       exp_p;
    logic [2:0][CW-1:0] got;
    string              nm;
    if (pending_points.size() == 0) begin
      $error("result beat with no sample pending");
      fail_count++;
      return;
    end
    exp_p = pending_points.pop_front();
    got   = {z, y, x};
    for (int k = 0; k < 3; k++) begin
      if (got[k] !== exp_p.lane[k]) begin
        nm = (k == 0) ? "x_out" : (k == 1) ? "y_out" : "z_out";
        $error("%s: expected %0d, got %0d", nm, $signed(exp_p.lane[k]), $signed(got[k]));
        fail_count++;
      end
    end
    if (sat !== exp_p.sat) begin
      $error("saturated: expected %0d, got %0d", exp_p.sat, sat);
      fail_count++;
    end
  endfunction

  function int pending();
    return pending_points.size();
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_WIDTH = 16;
  localparam int T_FRAC_BITS = 16;
  localparam int SETTLE      = 8;
  localparam int MAX_GAP     = 17;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 50;
  localparam logic [hsev_pkg::CFG_IDX_W-1:0] CFG_IDX_LAST = '1;
  localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};
  localparam logic [T_FRAC_BITS:0] T_MAX = '1;

  typedef enum int {SEG_RANDOM, SEG_GENTLE, SEG_EXTREME} seg_style_e;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_we_i;
  logic [hsev_pkg::CFG_IDX_W-1:0]    cfg_idx_i;
  logic [3*COORD_WIDTH-1:0]          cfg_wdata_i;
  logic                              start_i;
  logic                              busy_o;
  logic [T_FRAC_BITS:0]              param_t_i;
  logic                              mode_i;
  logic                              done_o;
  logic signed [COORD_WIDTH-1:0]     x_out_o;
  logic signed [COORD_WIDTH-1:0]     y_out_o;
  logic signed [COORD_WIDTH-1:0]     z_out_o;
  logic                              saturated_o;

  curve_checker sb;

  hermite_segment_evaluator_core #(
    .COORD_WIDTH(COORD_WIDTH),
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .param_t_i  (param_t_i),
    .mode_i     (mode_i),
    .done_o     (done_o),
    .x_out_o    (x_out_o),
    .y_out_o    (y_out_o),
    .z_out_o    (z_out_o),
    .saturated_o(saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Every result beat is checked at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_output(x_out_o, y_out_o, z_out_o, saturated_o);
    end
  end

  function automatic logic [3*COORD_WIDTH-1:0] pack3(logic [15:0] x, logic [15:0] y,
                                                     logic [15:0] z);
    return {z, y, x};
  endfunction

  function automatic logic [COORD_WIDTH-1:0] draw_lane(seg_style_e style);
    logic [COORD_WIDTH-1:0] v;
    case (style)
      SEG_GENTLE: v = COORD_WIDTH'($urandom_range(0, 2047) - 1024);
      SEG_EXTREME: begin
        case ($urandom_range(0, 4))
          0: v = 16'h7fff;
          1: v = 16'h8000;
          2: v = 16'h0000;
          3: v = 16'hffff;
          default: v = 16'h0001;
        endcase
      end
      default: v = COORD_WIDTH'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [T_FRAC_BITS:0] draw_t();
    logic [T_FRAC_BITS:0] t;
    case ($urandom_range(0, 19))
      0: t = '0;
      1: t = T_ONE;
      2: t = (T_FRAC_BITS+1)'($urandom_range(T_ONE + 1, T_MAX));
      3: t = (T_FRAC_BITS+1)'($urandom_range(1, 15));
      default: t = (T_FRAC_BITS+1)'($urandom_range(1, T_ONE - 1));
    endcase
    return t;
  endfunction

  // Register write beat; the caller lowers cfg_we_i after its last write.
  task automatic write_reg(logic [hsev_pkg::CFG_IDX_W-1:0] idx,
                           logic [3*COORD_WIDTH-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic load_segment(logic [3*COORD_WIDTH-1:0] y0, logic [3*COORD_WIDTH-1:0] s0,
                              logic [3*COORD_WIDTH-1:0] y1, logic [3*COORD_WIDTH-1:0] s1);
    write_reg(hsev_pkg::CFG_START_POINT, y0);
    write_reg(hsev_pkg::CFG_START_TANGENT, s0);
    write_reg(hsev_pkg::CFG_END_POINT, y1);
    write_reg(hsev_pkg::CFG_END_TANGENT, s1);
    cfg_we_i = 1'b0;
  endtask

  // Sends one sample beat after an optional idle gap; entered and left at a falling edge.
  task automatic send_sample(logic [T_FRAC_BITS:0] t, logic mode, int gap);
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i   = 1'b1;
    param_t_i = t;
    mode_i    = mode;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_sample(t, mode);
    @(negedge clk_i);
  endtask

  // Holds off the sender until every pending result has come back.
  task automatic drain();
    start_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic send_rand_gap(logic [T_FRAC_BITS:0] t, logic mode);
    send_sample(t, mode, $urandom_range(0, MAX_GAP));
  endtask

  initial begin
    seg_style_e style;
    bit         burst;
    sb          = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    start_i     = 1'b0;
    param_t_i   = '0;
    mode_i      = hsev_pkg::MODE_POSITION;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: the all-zero segment out of reset.
    send_rand_gap(T_ONE >> 1, hsev_pkg::MODE_POSITION);
    send_rand_gap('0, hsev_pkg::MODE_TANGENT);
    send_rand_gap(T_ONE, hsev_pkg::MODE_POSITION);
    drain();

    // Directed: a modest segment at both clamps, the smallest step, the midpoint and just below 1.0.
    load_segment(pack3(16'h0100, 16'hfe00, 16'h0000), pack3(16'h0080, 16'h0300, 16'hff00),
                 pack3(16'h0400, 16'h0100, 16'hfd00), pack3(16'hff00, 16'h0040, 16'h0200));
    send_rand_gap('0, hsev_pkg::MODE_POSITION);
    send_rand_gap('0, hsev_pkg::MODE_TANGENT);
    send_sample((T_FRAC_BITS+1)'(1), hsev_pkg::MODE_POSITION, 0);
    send_sample((T_FRAC_BITS+1)'(1), hsev_pkg::MODE_TANGENT, 0);
    send_sample(T_ONE >> 1, hsev_pkg::MODE_POSITION, 0);
    send_sample(T_ONE >> 1, hsev_pkg::MODE_TANGENT, 0);
    send_rand_gap(T_ONE - 1, hsev_pkg::MODE_POSITION);
    send_rand_gap(T_ONE - 1, hsev_pkg::MODE_TANGENT);
    send_rand_gap(T_ONE, hsev_pkg::MODE_POSITION);
    send_rand_gap(T_ONE, hsev_pkg::MODE_TANGENT);
    send_rand_gap(T_MAX, hsev_pkg::MODE_POSITION);
    send_rand_gap(T_MAX, hsev_pkg::MODE_TANGENT);
    drain();

    // Directed: a write to an unused index must leave the segment alone.
    write_reg(CFG_IDX_LAST, pack3(16'h7fff, 16'h8000, 16'h7fff));
    cfg_we_i = 1'b0;
    send_rand_gap(T_ONE >> 1, hsev_pkg::MODE_POSITION);
    send_rand_gap(T_ONE >> 2, hsev_pkg::MODE_TANGENT);
    drain();

    // Directed: full-scale endpoints and tangents that can drive lanes into saturation.
    load_segment(pack3(16'h8000, 16'h7fff, 16'h8000), pack3(16'h7fff, 16'h8000, 16'h7fff),
                 pack3(16'h7fff, 16'h8000, 16'h7fff), pack3(16'h7fff, 16'h8000, 16'h8000));
    send_sample((T_FRAC_BITS+1)'(21845), hsev_pkg::MODE_POSITION, 0);
    send_sample(T_ONE >> 1, hsev_pkg::MODE_TANGENT, 0);
    send_rand_gap((T_FRAC_BITS+1)'(49152), hsev_pkg::MODE_POSITION);
    send_rand_gap((T_FRAC_BITS+1)'(1), hsev_pkg::MODE_TANGENT);
    send_rand_gap(T_ONE - 1, hsev_pkg::MODE_POSITION);
    send_rand_gap(T_ONE - 1, hsev_pkg::MODE_TANGENT);
    drain();

    // Random phases: a fresh segment each time, an occasional write to an unused index, then a run of samples.
    for (int ph = 0; ph < PHASES; ph++) begin
      style = seg_style_e'(ph % 3);
      burst = ($urandom_range(0, 3) == 0);
      load_segment(pack3(draw_lane(style), draw_lane(style), draw_lane(style)),
                   pack3(draw_lane(style), draw_lane(style), draw_lane(style)),
                   pack3(draw_lane(style), draw_lane(style), draw_lane(style)),
                   pack3(draw_lane(style), draw_lane(style), draw_lane(style)));
      if ($urandom_range(0, 2) == 0) begin
        write_reg(hsev_pkg::CFG_IDX_W'($urandom_range(hsev_pkg::CFG_END_TANGENT + 1,
                                                      CFG_IDX_LAST)),
                  (3*COORD_WIDTH)'({$urandom, $urandom}));
        cfg_we_i = 1'b0;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_sample(draw_t(), 1'($urandom_range(0, 1)),
                    burst ? 0 : $urandom_range(0, MAX_GAP));
      end
      drain();
    end

    if (sb.fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hung pipeline: far beyond the slowest correct run.
  initial begin
    #400us;
    $display("Mismatches found");
    $finish;
  end
endmodule

FILE: filelist.f
hw/rtl/hsev_pkg.sv
hw/rtl/hermite_segment_evaluator_core.sv
dv/tb_top.sv
